### design/spi_nfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared types, codes and constants for the command sequencer blocks.
// ----------------------------------------------------------------------------
package spi_nfcs_pkg;

    localparam int ADDR_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 3;
    localparam int PAGE_BYTES = 256;
    localparam int CHUNK_W    = $clog2(PAGE_BYTES + 1);
    localparam int STEP_W     = 3;
    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_CFG);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IDENT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REPLY = 3'd4;

    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_ERASE = 2'd2;
    localparam logic [1:0] K_IDENT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_READ_OP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROG_OP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_OP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_OP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_OP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDENT_OP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_MASK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILLER    = 3'd7;

    typedef enum logic [1:0] {
        CL_REQUEST,
        CL_REPLY,
        CL_BAD
    } item_class_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WREN,
        PH_ADDR,
        PH_READ,
        PH_PROG,
        PH_POLLCMD,
        PH_POLL,
        PH_ID
    } phase_t;

    typedef struct packed {
        item_class_t       cls;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] length;
        logic [BYTE_W-1:0] write_byte;
        logic [BYTE_W-1:0] reply_byte;
    } queue_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_opcode;
        logic [BYTE_W-1:0] program_opcode;
        logic [BYTE_W-1:0] erase_opcode;
        logic [BYTE_W-1:0] enable_opcode;
        logic [BYTE_W-1:0] status_opcode;
        logic [BYTE_W-1:0] ident_opcode;
        logic [BYTE_W-1:0] busy_mask;
        logic [BYTE_W-1:0] filler_byte;
    } cfg_t;

    typedef struct packed {
        logic              release_select;
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic              need_data;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              id_valid;
        logic [15:0]       device_id;
        logic              done_res;
        logic              rejected;
    } result_t;

endpackage

### design/spi_nfcs_cfg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer configuration registers
// Holds the opcode, busy mask and filler byte registers written by the host.
// ----------------------------------------------------------------------------
module spi_nfcs_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [spi_nfcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]        cfg_data,
    output spi_nfcs_pkg::cfg_t                     cfg
);
    import spi_nfcs_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_opcode    <= 8'd3;
            cfg_reg.program_opcode <= 8'd2;
            cfg_reg.erase_opcode   <= 8'd32;
            cfg_reg.enable_opcode  <= 8'd6;
            cfg_reg.status_opcode  <= 8'd5;
            cfg_reg.ident_opcode   <= 8'd144;
            cfg_reg.busy_mask      <= 8'd1;
            cfg_reg.filler_byte    <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_READ_OP:   cfg_reg.read_opcode    <= cfg_data;
                REG_PROG_OP:   cfg_reg.program_opcode <= cfg_data;
                REG_ERASE_OP:  cfg_reg.erase_opcode   <= cfg_data;
                REG_ENABLE_OP: cfg_reg.enable_opcode  <= cfg_data;
                REG_STATUS_OP: cfg_reg.status_opcode  <= cfg_data;
                REG_IDENT_OP:  cfg_reg.ident_opcode   <= cfg_data;
                REG_BUSY_MASK: cfg_reg.busy_mask      <= cfg_data;
                REG_FILLER:    cfg_reg.filler_byte    <= cfg_data;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

endmodule

### design/spi_nfcs_front.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer front end
// Accepts input words, classifies the command and queues them for the back end.
// ----------------------------------------------------------------------------
module spi_nfcs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [spi_nfcs_pkg::CMD_W-1:0]    cmd,
    input  logic [spi_nfcs_pkg::ADDR_W-1:0]   address,
    input  logic [spi_nfcs_pkg::ADDR_W-1:0]   length,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]   write_byte,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]   reply_byte,
    output logic                              q_valid,
    input  logic                              q_pop,
    output spi_nfcs_pkg::queue_word_t         q_word
);
    import spi_nfcs_pkg::*;

    queue_word_t         store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;
    queue_word_t         new_word;

    assign in_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_word   = store_reg[rd_ptr_reg];

    always_comb
    begin
        new_word.kind       = cmd[1:0];
        new_word.address    = address;
        new_word.length     = length;
        new_word.write_byte = write_byte;
        new_word.reply_byte = reply_byte;
        if (cmd == CMD_REPLY)
        begin
            new_word.cls = CL_REPLY;
        end
        else if (cmd inside {CMD_READ, CMD_WRITE, CMD_ERASE, CMD_IDENT})
        begin
            new_word.cls = CL_REQUEST;
        end
        else
        begin
            new_word.cls = CL_BAD;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/spi_nfcs_back.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer back end
// Runs the sequence into an output register, one queued word per unstalled cycle.
// ----------------------------------------------------------------------------
module spi_nfcs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spi_nfcs_pkg::cfg_t          cfg,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  spi_nfcs_pkg::queue_word_t   q_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output spi_nfcs_pkg::result_t       res
);
    import spi_nfcs_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [1:0]          kind_reg;
    logic [1:0]          kind_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;
    logic [ADDR_W-1:0]   left_reg;
    logic [ADDR_W-1:0]   left_next;
    logic [CHUNK_W-1:0]  chunk_reg;
    logic [CHUNK_W-1:0]  chunk_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [BYTE_W-1:0]   id_high_reg;
    logic [BYTE_W-1:0]   id_high_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             res_reg;
    result_t             res_next;
    logic                fire;
    logic                do_prog;
    logic [CHUNK_W-1:0]  room;
    logic [CHUNK_W-1:0]  chunk_dec;
    logic [ADDR_W-1:0]   left_dec;
    logic [ADDR_W-1:0]   addr_inc;

    assign fire      = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = fire;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign room      = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(addr_reg % PAGE_BYTES);
    assign chunk_dec = CHUNK_W'(chunk_reg - 1'b1);
    assign left_dec  = ADDR_W'(left_reg - 1'b1);
    assign addr_inc  = ADDR_W'(addr_reg + 1'b1);

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        chunk_next   = chunk_reg;
        step_next    = step_reg;
        id_high_next = id_high_reg;
        res_next     = '0;
        do_prog      = 1'b0;

        if ((q_word.cls == CL_BAD)
            || (q_word.cls == CL_REQUEST && phase_reg != PH_IDLE)
            || (q_word.cls == CL_REPLY && phase_reg == PH_IDLE))
        begin
            res_next.rejected = 1'b1;
        end
        else if (q_word.cls == CL_REQUEST)
        begin
            kind_next = q_word.kind;
            addr_next = q_word.address;
            left_next = q_word.length;
            step_next = '0;
            if ((q_word.kind inside {K_READ, K_WRITE}) && q_word.length == '0)
            begin
                res_next.done_res = 1'b1;
            end
            else
            begin
                res_next.release_select = 1'b1;
                res_next.send_valid     = 1'b1;
                case (q_word.kind)
                    K_READ:
                    begin
                        res_next.send_byte = cfg.read_opcode;
                        phase_next         = PH_ADDR;
                    end
                    K_IDENT:
                    begin
                        res_next.send_byte = cfg.ident_opcode;
                        phase_next         = PH_ID;
                    end
                    default:
                    begin
                        res_next.send_byte = cfg.enable_opcode;
                        phase_next         = PH_WREN;
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_WREN:
                begin
                    res_next.release_select = 1'b1;
                    res_next.send_valid     = 1'b1;
                    step_next               = '0;
                    if (kind_reg == K_WRITE)
                    begin
                        chunk_next = (left_reg < ADDR_W'(room)) ? CHUNK_W'(left_reg) : room;
                        res_next.send_byte = cfg.program_opcode;
                    end
                    else
                    begin
                        res_next.send_byte = cfg.erase_opcode;
                    end
                    phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    if (step_reg < 3'd3)
                    begin
                        res_next.send_valid = 1'b1;
                        case (step_reg)
                            3'd0:    res_next.send_byte = addr_reg[23:16];
                            3'd1:    res_next.send_byte = addr_reg[15:8];
                            default: res_next.send_byte = addr_reg[7:0];
                        endcase
                        step_next = STEP_W'(step_reg + 1'b1);
                        res_next.need_data = (step_reg == 3'd2) && (kind_reg == K_WRITE);
                    end
                    else if (kind_reg == K_READ)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = cfg.filler_byte;
                        phase_next          = PH_READ;
                    end
                    else if (kind_reg == K_WRITE)
                    begin
                        do_prog = 1'b1;
                    end
                    else
                    begin
                        res_next.release_select = 1'b1;
                        res_next.send_valid     = 1'b1;
                        res_next.send_byte      = cfg.status_opcode;
                        phase_next              = PH_POLLCMD;
                    end
                end
                PH_READ:
                begin
                    res_next.read_valid = 1'b1;
                    res_next.read_byte  = q_word.reply_byte;
                    left_next           = left_dec;
                    addr_next           = addr_inc;
                    if (left_dec != '0)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = cfg.filler_byte;
                    end
                    else
                    begin
                        res_next.release_select = 1'b1;
                        res_next.done_res       = 1'b1;
                        phase_next              = PH_IDLE;
                    end
                end
                PH_PROG:
                begin
                    do_prog = 1'b1;
                end
                PH_POLLCMD:
                begin
                    res_next.send_valid = 1'b1;
                    res_next.send_byte  = cfg.filler_byte;
                    phase_next          = PH_POLL;
                end
                PH_POLL:
                begin
                    if ((q_word.reply_byte & cfg.busy_mask) != '0)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = cfg.filler_byte;
                    end
                    else if (kind_reg == K_WRITE && left_reg != '0)
                    begin
                        res_next.release_select = 1'b1;
                        res_next.send_valid     = 1'b1;
                        res_next.send_byte      = cfg.enable_opcode;
                        phase_next              = PH_WREN;
                    end
                    else
                    begin
                        res_next.release_select = 1'b1;
                        res_next.done_res       = 1'b1;
                        phase_next              = PH_IDLE;
                    end
                end
                PH_ID:
                begin
                    if (step_reg < 3'd4)
                    begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = cfg.filler_byte;
                        step_next           = STEP_W'(step_reg + 1'b1);
                    end
                    else if (step_reg == 3'd4)
                    begin
                        id_high_next        = q_word.reply_byte;
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = cfg.filler_byte;
                        step_next           = 3'd5;
                    end
                    else
                    begin
                        res_next.id_valid       = 1'b1;
                        res_next.device_id      = {id_high_reg, q_word.reply_byte};
                        res_next.release_select = 1'b1;
                        res_next.done_res       = 1'b1;
                        phase_next              = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_prog)
            begin
                res_next.send_valid = 1'b1;
                if (chunk_reg != '0)
                begin
                    res_next.send_byte = q_word.write_byte;
                    chunk_next         = chunk_dec;
                    left_next          = left_dec;
                    addr_next          = addr_inc;
                    res_next.need_data = (chunk_dec != '0);
                    phase_next         = PH_PROG;
                end
                else
                begin
                    res_next.release_select = 1'b1;
                    res_next.send_byte      = cfg.status_opcode;
                    phase_next              = PH_POLLCMD;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_reg      <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            chunk_reg     <= '0;
            step_reg      <= '0;
            id_high_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg   <= phase_next;
                kind_reg    <= kind_next;
                addr_reg    <= addr_next;
                left_reg    <= left_next;
                chunk_reg   <= chunk_next;
                step_reg    <= step_next;
                id_high_reg <= id_high_next;
            end
        end
    end

endmodule

### design/spi_nor_flash_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core
// Turns host requests and bus replies into SPI byte exchanges and results.
// ----------------------------------------------------------------------------
// Every accepted word, whether a host request or a bus reply, yields exactly one
// result word. A new word can be accepted every clock cycle while the queue is not
// full: the front end queues up to two classified words, the back end sequencer
// consumes one per cycle whenever its output register is empty or being taken, and
// a result is registered in that output register when its word is consumed.
// Throughput is set by the state update of the back end sequencer, so one word per
// cycle is sustained while the result side does not stall.
module spi_nor_flash_command_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spi_nfcs_pkg::CMD_W-1:0]      cmd,
    input  logic [spi_nfcs_pkg::ADDR_W-1:0]     address,
    input  logic [spi_nfcs_pkg::ADDR_W-1:0]     length,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]     write_byte,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]     reply_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                release_select,
    output logic                                send_valid,
    output logic [spi_nfcs_pkg::BYTE_W-1:0]     send_byte,
    output logic                                need_data,
    output logic                                read_valid,
    output logic [spi_nfcs_pkg::BYTE_W-1:0]     read_byte,
    output logic                                id_valid,
    output logic [15:0]                         device_id,
    output logic                                done_res,
    output logic                                rejected,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spi_nfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]     cfg_data
);
    import spi_nfcs_pkg::*;

    cfg_t        cfg;
    logic        q_valid;
    logic        q_pop;
    queue_word_t q_word;
    result_t     res;

    spi_nfcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spi_nfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .address    (address),
        .length     (length),
        .write_byte (write_byte),
        .reply_byte (reply_byte),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_word     (q_word)
    );

    spi_nfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign release_select = res.release_select;
    assign send_valid     = res.send_valid;
    assign send_byte      = res.send_byte;
    assign need_data      = res.need_data;
    assign read_valid     = res.read_valid;
    assign read_byte      = res.read_byte;
    assign id_valid       = res.id_valid;
    assign device_id      = res.device_id;
    assign done_res       = res.done_res;
    assign rejected       = res.rejected;

endmodule

### design/spi_nfcs_checker.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer port checker
// Checks result word consistency and output handshake rules at the top level.
// ----------------------------------------------------------------------------
module spi_nfcs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        release_select,
    input  logic        send_valid,
    input  logic [7:0]  send_byte,
    input  logic        need_data,
    input  logic        read_valid,
    input  logic [7:0]  read_byte,
    input  logic        id_valid,
    input  logic [15:0] device_id,
    input  logic        done_res,
    input  logic        rejected
);

    a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !send_valid && !done_res && !release_select
                                  && !read_valid && !id_valid)
        else $error("Rejected word carries other results.");

    a_done_sends_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !send_valid && !need_data)
        else $error("Completion word also sends a byte.");

    a_need_data_with_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && need_data |-> send_valid)
        else $error("Data requested without a byte being sent.");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (read_valid || read_byte == 8'd0) && (id_valid || device_id == 16'd0)
                      && (send_valid || send_byte == 8'd0))
        else $error("Unused result field is not zero.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(send_byte) && $stable(done_res))
        else $error("Stalled result word changed.");

endmodule

bind spi_nor_flash_command_sequencer_core spi_nfcs_checker u_spi_nfcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .release_select (release_select),
    .send_valid     (send_valid),
    .send_byte      (send_byte),
    .need_data      (need_data),
    .read_valid     (read_valid),
    .read_byte      (read_byte),
    .id_valid       (id_valid),
    .device_id      (device_id),
    .done_res       (done_res),
    .rejected       (rejected)
);

### bench/spi_nor_flash_command_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer checker
// Watches the word and register channels of the sequencer core, keeps its own
// model of the command sequence and compares every result word, field by
// field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [spi_nfcs_pkg::CMD_W-1:0]     cmd,
    input  logic [spi_nfcs_pkg::ADDR_W-1:0]    address,
    input  logic [spi_nfcs_pkg::ADDR_W-1:0]    length,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]    write_byte,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]    reply_byte,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               release_select,
    input  logic                               send_valid,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]    send_byte,
    input  logic                               need_data,
    input  logic                               read_valid,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]    read_byte,
    input  logic                               id_valid,
    input  logic [15:0]                        device_id,
    input  logic                               done_res,
    input  logic                               rejected,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [spi_nfcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spi_nfcs_pkg::BYTE_W-1:0]    cfg_data,
    output int                                 fail_count,
    output int                                 due_count,
    output int                                 checked_count
);
    import spi_nfcs_pkg::*;

    cfg_t                regs;
    phase_t              seq_phase;
    logic [1:0]          op_kind;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   bytes_rem;
    logic [CHUNK_W-1:0]  chunk_rem;
    logic [STEP_W-1:0]   step;
    logic [BYTE_W-1:0]   id_hi;
    result_t             due_results[$];
    int                  errors = 0;
    int                  checked = 0;

    task automatic program_byte(input logic [BYTE_W-1:0] wb, inout result_t r);
        if (chunk_rem != '0) begin
            r.send_valid = 1'b1;
            r.send_byte = wb;
            chunk_rem = chunk_rem - 1'b1;
            bytes_rem = bytes_rem - 1'b1;
            cur_addr = cur_addr + 1'b1;
            r.need_data = (chunk_rem != '0);
            seq_phase = PH_PROG;
        end else begin
            r.release_select = 1'b1;
            r.send_valid = 1'b1;
            r.send_byte = regs.status_opcode;
            seq_phase = PH_POLLCMD;
        end
    endtask

    task automatic advance_sequencer(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                                     input logic [ADDR_W-1:0] l, input logic [BYTE_W-1:0] wb,
                                     input logic [BYTE_W-1:0] rb, output result_t r);
        int                room;
        logic [ADDR_W-1:0] shifted;
        r = '0;
        if (c > CMD_REPLY || (c < CMD_REPLY && seq_phase != PH_IDLE)
                || (c == CMD_REPLY && seq_phase == PH_IDLE)) begin
            r.rejected = 1'b1;
        end else if (c < CMD_REPLY) begin
            op_kind = c[1:0];
            cur_addr = a;
            bytes_rem = l;
            step = '0;
            if ((c == CMD_READ || c == CMD_WRITE) && l == '0) begin
                r.done_res = 1'b1;
            end else begin
                r.release_select = 1'b1;
                r.send_valid = 1'b1;
                if (c == CMD_READ) begin
                    r.send_byte = regs.read_opcode;
                    seq_phase = PH_ADDR;
                end else if (c == CMD_IDENT) begin
                    r.send_byte = regs.ident_opcode;
                    seq_phase = PH_ID;
                end else begin
                    r.send_byte = regs.enable_opcode;
                    seq_phase = PH_WREN;
                end
            end
        end else begin
            case (seq_phase)
                PH_WREN:
                begin
                    r.release_select = 1'b1;
                    r.send_valid = 1'b1;
                    step = '0;
                    if (op_kind == K_WRITE) begin
                        room = PAGE_BYTES - (int'(cur_addr) % PAGE_BYTES);
                        if (int'(bytes_rem) < room)
                            chunk_rem = bytes_rem[CHUNK_W-1:0];
                        else
                            chunk_rem = CHUNK_W'(room);
                        r.send_byte = regs.program_opcode;
                    end else begin
                        r.send_byte = regs.erase_opcode;
                    end
                    seq_phase = PH_ADDR;
                end
                PH_ADDR:
                begin
                    if (step < 3'd3) begin
                        shifted = cur_addr >> (16 - 8 * int'(step));
                        r.send_valid = 1'b1;
                        r.send_byte = shifted[BYTE_W-1:0];
                        step = step + 1'b1;
                        if (step == 3'd3 && op_kind == K_WRITE)
                            r.need_data = 1'b1;
                    end else if (op_kind == K_READ) begin
                        r.send_valid = 1'b1;
                        r.send_byte = regs.filler_byte;
                        seq_phase = PH_READ;
                    end else if (op_kind == K_WRITE) begin
                        program_byte(wb, r);
                    end else begin
                        r.release_select = 1'b1;
                        r.send_valid = 1'b1;
                        r.send_byte = regs.status_opcode;
                        seq_phase = PH_POLLCMD;
                    end
                end
                PH_READ:
                begin
                    r.read_valid = 1'b1;
                    r.read_byte = rb;
                    bytes_rem = bytes_rem - 1'b1;
                    cur_addr = cur_addr + 1'b1;
                    if (bytes_rem != '0) begin
                        r.send_valid = 1'b1;
                        r.send_byte = regs.filler_byte;
                    end else begin
                        r.release_select = 1'b1;
                        r.done_res = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                end
                PH_PROG:
                begin
                    program_byte(wb, r);
                end
                PH_POLLCMD:
                begin
                    r.send_valid = 1'b1;
                    r.send_byte = regs.filler_byte;
                    seq_phase = PH_POLL;
                end
                PH_POLL:
                begin
                    if ((rb & regs.busy_mask) != '0) begin
                        r.send_valid = 1'b1;
                        r.send_byte = regs.filler_byte;
                    end else if (op_kind == K_WRITE && bytes_rem != '0) begin
                        r.release_select = 1'b1;
                        r.send_valid = 1'b1;
                        r.send_byte = regs.enable_opcode;
                        seq_phase = PH_WREN;
                    end else begin
                        r.release_select = 1'b1;
                        r.done_res = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                end
                PH_ID:
                begin
                    if (step < 3'd4) begin
                        r.send_valid = 1'b1;
                        r.send_byte = regs.filler_byte;
                        step = step + 1'b1;
                    end else if (step == 3'd4) begin
                        id_hi = rb;
                        r.send_valid = 1'b1;
                        r.send_byte = regs.filler_byte;
                        step = 3'd5;
                    end else begin
                        r.id_valid = 1'b1;
                        r.device_id = {id_hi, rb};
                        r.release_select = 1'b1;
                        r.done_res = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                end
                default:
                begin
                    seq_phase = PH_IDLE;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n) begin
            regs = '{read_opcode: 8'd3, program_opcode: 8'd2, erase_opcode: 8'h20,
                     enable_opcode: 8'd6, status_opcode: 8'd5, ident_opcode: 8'h90,
                     busy_mask: 8'd1, filler_byte: 8'hff};
            seq_phase = PH_IDLE;
            op_kind = '0;
            cur_addr = '0;
            bytes_rem = '0;
            chunk_rem = '0;
            step = '0;
            id_hi = '0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_READ_OP:   regs.read_opcode = cfg_data;
                    REG_PROG_OP:   regs.program_opcode = cfg_data;
                    REG_ERASE_OP:  regs.erase_opcode = cfg_data;
                    REG_ENABLE_OP: regs.enable_opcode = cfg_data;
                    REG_STATUS_OP: regs.status_opcode = cfg_data;
                    REG_IDENT_OP:  regs.ident_opcode = cfg_data;
                    REG_BUSY_MASK: regs.busy_mask = cfg_data;
                    default:       regs.filler_byte = cfg_data;
                endcase
            end
            if (out_valid && !out_stall) begin
                checked++;
                if (due_results.size() == 0) begin
                    $error("result word arrived with no word outstanding");
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("release_select", 16'(want.release_select), 16'(release_select));
                    check_field("send_valid", 16'(want.send_valid), 16'(send_valid));
                    check_field("send_byte", 16'(want.send_byte), 16'(send_byte));
                    check_field("need_data", 16'(want.need_data), 16'(need_data));
                    check_field("read_valid", 16'(want.read_valid), 16'(read_valid));
                    check_field("read_byte", 16'(want.read_byte), 16'(read_byte));
                    check_field("id_valid", 16'(want.id_valid), 16'(id_valid));
                    check_field("device_id", want.device_id, device_id);
                    check_field("done_res", 16'(want.done_res), 16'(done_res));
                    check_field("rejected", 16'(want.rejected), 16'(rejected));
                end
            end
            if (in_valid && !in_stall) begin
                advance_sequencer(cmd, address, length, write_byte, reply_byte, want);
                due_results.push_back(want);
            end
        end
        due_count <= due_results.size();
        fail_count <= errors;
        checked_count <= checked;
    end

endmodule

### bench/spi_nor_flash_command_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core testbench
// Drives scripted flash operations (reads, page-split writes, erases and ID
// reads with random status polling), stray and rejected words and several
// register settings through the core, with random idling on both sides.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_core_tb;
    import spi_nfcs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd = CMD_REPLY;
    logic [ADDR_W-1:0]    address = '0;
    logic [ADDR_W-1:0]    length = '0;
    logic [BYTE_W-1:0]    write_byte = '0;
    logic [BYTE_W-1:0]    reply_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 release_select;
    logic                 send_valid;
    logic [BYTE_W-1:0]    send_byte;
    logic                 need_data;
    logic                 read_valid;
    logic [BYTE_W-1:0]    read_byte;
    logic                 id_valid;
    logic [15:0]          device_id;
    logic                 done_res;
    logic                 rejected;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    int fail_count;
    int due_count;
    int checked_count;

    logic [CFG_IDX_W-1:0] reg_order [NUM_CFG] = '{REG_READ_OP, REG_PROG_OP, REG_ERASE_OP,
        REG_ENABLE_OP, REG_STATUS_OP, REG_IDENT_OP, REG_BUSY_MASK, REG_FILLER};

    logic [BYTE_W-1:0] mask_now = 8'd1;
    bit noisy = 1'b0;
    bit calm = 1'b0;
    bit squeeze_go = 1'b0;
    bit squeezed = 1'b0;
    int words_sent = 0;
    int reads = 0;
    int writes = 0;
    int erases = 0;
    int idents = 0;
    int strays = 0;
    int cfg_writes = 0;

    spi_nor_flash_command_sequencer_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .address(address), .length(length),
        .write_byte(write_byte), .reply_byte(reply_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .release_select(release_select), .send_valid(send_valid), .send_byte(send_byte),
        .need_data(need_data), .read_valid(read_valid), .read_byte(read_byte),
        .id_valid(id_valid), .device_id(device_id), .done_res(done_res),
        .rejected(rejected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    spi_nor_flash_command_sequencer_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .address(address), .length(length),
        .write_byte(write_byte), .reply_byte(reply_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .release_select(release_select), .send_valid(send_valid), .send_byte(send_byte),
        .need_data(need_data), .read_valid(read_valid), .read_byte(read_byte),
        .id_valid(id_valid), .device_id(device_id), .done_res(done_res),
        .rejected(rejected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .due_count(due_count), .checked_count(checked_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #1000000;
        $display("spi_nor_flash_command_sequencer_core verification failed");
        $finish;
    end

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (squeeze_go && !squeezed) begin
                squeezed = 1'b1;
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 24);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom);
    endfunction

    task automatic put_word(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                            input logic [ADDR_W-1:0] l, input logic [BYTE_W-1:0] wb,
                            input logic [BYTE_W-1:0] rb);
        if (!calm && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!calm && $urandom_range(99) < 24);
        end
        in_valid <= 1'b1;
        cmd <= c;
        address <= a;
        length <= l;
        write_byte <= wb;
        reply_byte <= rb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic stray_word(input bit busy);
        logic [CMD_W-1:0] c;
        if ($urandom_range(1) == 0)
            c = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        else if (busy)
            c = CMD_W'($urandom_range(CMD_IDENT, CMD_READ));
        else
            c = CMD_REPLY;
        put_word(c, ADDR_W'($urandom), ADDR_W'($urandom), any_byte(), any_byte());
        strays++;
    endtask

    task automatic reply(input logic [BYTE_W-1:0] wb, input logic [BYTE_W-1:0] rb);
        if (noisy && $urandom_range(99) < 6)
            stray_word(1'b1);
        put_word(CMD_REPLY, ADDR_W'($urandom), ADDR_W'($urandom), wb, rb);
    endtask

    task automatic poll_status();
        int                spins;
        logic [BYTE_W-1:0] b;
        spins = (mask_now == '0) ? 0 : int'($urandom_range(3));
        repeat (spins)
        begin
            do
                b = any_byte();
            while ((b & mask_now) == '0);
            reply(any_byte(), b);
        end
        reply(any_byte(), any_byte() & ~mask_now);
    endtask

    task automatic run_read(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] l);
        put_word(CMD_READ, a, l, any_byte(), any_byte());
        reads++;
        if (l != '0)
            repeat (int'(l) + 4) reply(any_byte(), any_byte());
    endtask

    task automatic run_write(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] l);
        int                left;
        int                room;
        int                chunk;
        logic [ADDR_W-1:0] at;
        put_word(CMD_WRITE, a, l, any_byte(), any_byte());
        writes++;
        left = int'(l);
        at = a;
        while (left > 0)
        begin
            room = PAGE_BYTES - (int'(at) % PAGE_BYTES);
            chunk = (left < room) ? left : room;
            repeat (chunk + 6) reply(any_byte(), any_byte());
            poll_status();
            left -= chunk;
            at = ADDR_W'(int'(at) + chunk);
        end
    endtask

    task automatic run_erase(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] l);
        put_word(CMD_ERASE, a, l, any_byte(), any_byte());
        erases++;
        repeat (6) reply(any_byte(), any_byte());
        poll_status();
    endtask

    task automatic run_ident(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] l);
        put_word(CMD_IDENT, a, l, any_byte(), any_byte());
        idents++;
        repeat (6) reply(any_byte(), any_byte());
    endtask

    task automatic load_regs(input int style);
        logic [BYTE_W-1:0] val;
        int                i;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (due_count == 0);
        repeat (4) @(posedge clk);
        for (i = 0; i < NUM_CFG; i++)
        begin
            if (style == 0)
                val = 8'hff;
            else if (style == 1)
                val = 8'h00;
            else
                val = any_byte();
            if (reg_order[i] == REG_BUSY_MASK) begin
                if (style > 1 && $urandom_range(1) == 0)
                    val = BYTE_W'(1 << $urandom_range(7));
                mask_now = val;
            end
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_op();
        int                pick;
        int                n;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(99);
        a = ADDR_W'($urandom);
        if (pick < 30) begin
            if ($urandom_range(49) == 0)
                n = $urandom_range(300, 200);
            else if ($urandom_range(9) == 0)
                n = $urandom_range(40, 9);
            else
                n = $urandom_range(8, 1);
            run_read(a, ADDR_W'(n));
        end else if (pick < 60) begin
            if ($urandom_range(1) == 0)
                a[7:0] = BYTE_W'(PAGE_BYTES - int'($urandom_range(16, 1)));
            if ($urandom_range(9) == 0)
                a = ADDR_W'(24'hffffff - $urandom_range(6));
            if ($urandom_range(49) == 0)
                n = $urandom_range(520, 250);
            else if ($urandom_range(9) == 0)
                n = $urandom_range(40, 13);
            else
                n = $urandom_range(12, 1);
            run_write(a, ADDR_W'(n));
        end else if (pick < 75) begin
            run_erase(a, ADDR_W'($urandom));
        end else if (pick < 85) begin
            run_ident(a, ADDR_W'($urandom));
        end else if (pick < 90) begin
            if ($urandom_range(1) == 0)
                run_read(a, '0);
            else
                run_write(a, '0);
        end else begin
            repeat ($urandom_range(3, 1)) stray_word(1'b0);
        end
    endtask

    initial
    begin : stimulus
        int ph;
        int phase_end;
        wait (rst_n);
        @(posedge clk);

        put_word(CMD_REPLY, '0, '0, '0, '0);
        strays++;
        put_word(CMD_UNUSED_HI, 24'hffffff, 24'hffffff, 8'hff, 8'hff);
        strays++;
        run_read(24'hffffff, '0);
        run_write(24'h000000, '0);
        run_ident(24'h000000, 24'hffffff);

        // A request and an unused code arrive in the middle of a read.
        put_word(CMD_READ, 24'hffffff, 24'd2, 8'h00, 8'h00);
        reads++;
        reply(8'hff, 8'hff);
        put_word(CMD_WRITE, 24'h000100, 24'd1, 8'h00, 8'h00);
        put_word(CMD_UNUSED_LO, 24'h000000, 24'h000000, 8'h00, 8'h00);
        strays += 2;
        repeat (5) reply(any_byte(), any_byte());

        run_erase(24'hffffff, 24'hffffff);
        run_write(24'hffffff, 24'd2);

        noisy = 1'b1;
        for (ph = 0; ph < 6; ph++)
        begin
            load_regs(ph);
            calm = (ph == 3);
            phase_end = words_sent + 290;
            if (ph == 2) begin
                squeeze_go = 1'b1;
                run_read(ADDR_W'($urandom), 24'd40);
            end
            while (words_sent < phase_end)
                random_op();
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (due_count == 0);
        repeat (10) @(posedge clk);

        $display("Run covered %0d words: %0d reads, %0d writes, %0d erases, %0d ID reads, %0d strays.",
                 words_sent, reads, writes, erases, idents, strays);
        $display("It made %0d register writes over six settings and compared %0d result words.",
                 cfg_writes, checked_count);
        if (fail_count == 0)
            $display("spi_nor_flash_command_sequencer_core verification clean");
        else
            $display("spi_nor_flash_command_sequencer_core verification failed");
        $finish;
    end

endmodule
